FILE: rtl/core/bvr_pkg.sv
// ----------------------------------------------------------------------------
// bvr_pkg: shared types and constants of the bilinear volume resampler
// Sizes, field widths, register indexes, controller states and the command
// and status records that join the controller and the datapath.
// ----------------------------------------------------------------------------
package bvr_pkg;

  localparam int MAX_WIDTH  = 128;
  localparam int MAX_HEIGHT = 128;
  localparam int MAX_SLICES = 16;
  localparam int FRAC_BITS  = 16;

  localparam int X_W    = $clog2(MAX_WIDTH);
  localparam int Y_W    = $clog2(MAX_HEIGHT);
  localparam int S_W    = $clog2(MAX_SLICES);
  localparam int ADDR_W = S_W + Y_W + X_W;
  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT * MAX_SLICES;

  localparam int PX_W       = 7;
  localparam int SL_W       = 4;
  localparam int SIZE_W     = 8;
  localparam int CNT_W      = 5;
  localparam int VAL_W      = 32;
  localparam int ERR_W      = 31;
  localparam int AREA_W     = 2 * SIZE_W;
  localparam int DIV_W      = VAL_W + AREA_W;
  localparam int DVS_W      = AREA_W;
  localparam int WGT_W      = FRAC_BITS + 1;
  localparam int PROD_W     = VAL_W + WGT_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  localparam logic [VAL_W-1:0] SIGN_BIAS = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic [VAL_W-1:0] VAL_MAX   = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic [ERR_W-1:0] ERR_MAX   = {ERR_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OLD_WIDTH, CFG_OLD_HEIGHT, CFG_NEW_WIDTH, CFG_NEW_HEIGHT,
    CFG_SLICE_COUNT, CFG_USE_ERRORS, CFG_KEEP_TOTAL
  } cfg_idx_t;

  typedef enum logic [1:0] {DIV_X, DIV_Y, DIV_VAL, DIV_ERR} div_sel_t;

  typedef enum logic [1:0] {C00, C10, C01, C11} corner_t;

  typedef enum logic [2:0] {L_V0, L_V1, L_VY, L_E0, L_E1, L_EY} lerp_step_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DIV_START, S_DIV_WAIT, S_RD, S_RD_WAIT,
    S_LERP_A, S_LERP_B, S_LERP_SUM, S_FINISH
  } state_t;

  typedef struct packed {
    logic       load;
    logic       div_start;
    logic       div_cap;
    div_sel_t   div_sel;
    logic       rd_en;
    corner_t    corner;
    logic       lerp_a;
    logic       lerp_b;
    logic       lerp_sum;
    lerp_step_t lerp_idx;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic item_valid;
    logic op;
    logic bad;
    logic div_busy;
    logic div_done;
    logic use_err;
    logic keep_tot;
    logic out_free;
  } sts_t;

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input int hi);
    if (v == '0) return SIZE_W'(1);
    if (int'(v) > hi) return SIZE_W'(hi);
    return v;
  endfunction

endpackage

FILE: rtl/core/bvr_if.sv
// ----------------------------------------------------------------------------
// bvr_if: channel interfaces of the resampler
// Item, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface bvr_item_if;
  logic                         valid;
  logic                         ready;
  logic                         op;
  logic [bvr_pkg::PX_W-1:0]     pix_x;
  logic [bvr_pkg::PX_W-1:0]     pix_y;
  logic [bvr_pkg::SL_W-1:0]     slice;
  logic signed [bvr_pkg::VAL_W-1:0] sample_value;
  logic [bvr_pkg::ERR_W-1:0]    sample_error;
  modport source (output valid, op, pix_x, pix_y, slice, sample_value, sample_error,
                  input ready);
  modport sink (input valid, op, pix_x, pix_y, slice, sample_value, sample_error,
                output ready);
endinterface

interface bvr_result_if;
  logic                             valid;
  logic                             ready;
  logic signed [bvr_pkg::VAL_W-1:0] result_value;
  logic [bvr_pkg::ERR_W-1:0]        result_error;
  logic                             bad_request;
  modport source (output valid, result_value, result_error, bad_request, input ready);
  modport sink (input valid, result_value, result_error, bad_request, output ready);
endinterface

interface bvr_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [bvr_pkg::CFG_IDX_W-1:0]    index;
  logic [bvr_pkg::CFG_DATA_W-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/core/bilinear_volume_resampler_unit.sv
// ----------------------------------------------------------------------------
// bilinear_volume_resampler_unit: pixel-centred bilinear frame resampler
// Stores a stack of source frames and returns resampled pixels on request.
// ----------------------------------------------------------------------------
// Usage:
//   item   - one beat per operation. op 0 stores sample_value/sample_error at
//            (pix_x, pix_y, slice) of the source stack; writes outside the
//            source frame are dropped. op 1 requests new pixel (pix_x, pix_y)
//            of a slice and yields exactly one result beat.
//   result - result_value (Q16.16, saturated), result_error, bad_request.
//            Writes yield no result.
//   cfg    - register writes (index 0..6), always ready; write only while
//            the block is idle.
// Sequence: a write completes in its accept cycle. A request runs the restoring
//   divider once per axis (a start step, 48 quotient bits and a capture step),
//   reads the four corners through the registered memory read, runs three or
//   six interpolation steps (multiply, multiply, sum) on the single multiplier
//   and loads the result register; keep_total adds one division for each
//   field that it scales. The next item is taken in the cycle after the
//   result is loaded. A request outside the new frame goes straight to the
//   result stage without division or reads.
// Reset clears the controller and the result valid flag and restores the
//   register defaults; the sample memories are not cleared.
// A stalled receiver holds the result register; the block still accepts the
//   next beat and finishes it up to the result stage, then waits.
// ----------------------------------------------------------------------------
module bilinear_volume_resampler_unit
  import bvr_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  bvr_item_if.sink     item,
  bvr_result_if.source result,
  bvr_cfg_if.sink      cfg
);
  cmd_t cmd;
  sts_t sts;
  logic in_ready;
  logic [VAL_W-1:0] out_value;

  // configuration is taken in any cycle
  assign cfg.ready  = 1'b1;
  assign item.ready = in_ready;

  bvr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .sts      (sts),
    .cmd      (cmd),
    .in_ready (in_ready)
  );

  bvr_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg.valid && cfg.ready),
    .cfg_index  (cfg.index),
    .cfg_data   (cfg.data),
    .item_valid (item.valid),
    .item_op    (item.op),
    .item_x     (item.pix_x),
    .item_y     (item.pix_y),
    .item_slice (item.slice),
    .item_value (item.sample_value),
    .item_error (item.sample_error),
    .cmd        (cmd),
    .sts        (sts),
    .out_ready  (result.ready),
    .out_valid  (result.valid),
    .out_value  (out_value),
    .out_error  (result.result_error),
    .out_bad    (result.bad_request)
  );

  assign result.result_value = out_value;

  // a rejected request carries zero payload
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.bad_request |->
      result.result_value == '0 && result.result_error == '0)
    else $error("bad request with nonzero payload");

  // the divider is never restarted mid-division
  a_div_start: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> !sts.div_busy)
    else $error("divider started while busy");

  // no result beat right after reset
  a_rst_out: assert property (@(posedge clk)
    rst |=> !result.valid)
    else $error("result valid after reset");

  // an accepted request always moves the controller out of the ready state
  a_load_once: assert property (@(posedge clk) disable iff (rst)
    cmd.load && item.op && !cmd.out_load |=> !item.ready)
    else $error("request accepted without starting work");
endmodule

FILE: rtl/core/bvr_div.sv
// ----------------------------------------------------------------------------
// bvr_div: restoring divider
// One quotient bit per cycle; done pulses once the quotient is final.
// ----------------------------------------------------------------------------
module bvr_div
  import bvr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DIV_W-1:0]  dividend,
  input  logic [DVS_W-1:0]  divisor,
  output logic              busy,
  output logic              done,
  output logic [DIV_W-1:0]  quotient
);
  localparam int CW = $clog2(DIV_W + 1);

  logic [DVS_W:0]   rem;
  logic [DVS_W-1:0] dvs;
  logic [CW-1:0]    cnt;
  logic [DVS_W:0]   trial;
  logic             fits;

  assign trial = {rem[DVS_W-1:0], quotient[DIV_W-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CW'(1);
        if (cnt == CW'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvs      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= fits ? trial - {1'b0, dvs} : trial;
      quotient <= {quotient[DIV_W-2:0], fits};
    end
  end
endmodule

FILE: rtl/core/bvr_ctrl.sv
// ----------------------------------------------------------------------------
// bvr_ctrl: sequencer of the resampler
// Steps a request through coordinate division, corner reads, interpolation
// and optional area scaling; writes complete in the accept cycle.
// ----------------------------------------------------------------------------
module bvr_ctrl
  import bvr_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  bvr_pkg::sts_t sts,
  output bvr_pkg::cmd_t cmd,
  output logic          in_ready
);
  state_t     state, state_next;
  div_sel_t   sel, sel_next;
  corner_t    corner, corner_next;
  lerp_step_t lstep, lstep_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      sel    <= DIV_X;
      corner <= C00;
      lstep  <= L_V0;
    end else begin
      state  <= state_next;
      sel    <= sel_next;
      corner <= corner_next;
      lstep  <= lstep_next;
    end
  end

  always_comb begin
    state_next  = state;
    sel_next    = sel;
    corner_next = corner;
    lstep_next  = lstep;
    unique case (state)
      S_IDLE: begin
        if (sts.item_valid && sts.op) begin
          if (sts.bad) begin
            state_next = S_FINISH;
          end else begin
            state_next = S_DIV_START;
            sel_next   = DIV_X;
          end
        end
      end
      S_DIV_START: state_next = S_DIV_WAIT;
      S_DIV_WAIT: begin
        if (sts.div_done) begin
          unique case (sel)
            DIV_X: begin
              sel_next   = DIV_Y;
              state_next = S_DIV_START;
            end
            DIV_Y: begin
              corner_next = C00;
              state_next  = S_RD;
            end
            DIV_VAL: begin
              if (sts.use_err) begin
                sel_next   = DIV_ERR;
                state_next = S_DIV_START;
              end else begin
                state_next = S_FINISH;
              end
            end
            DIV_ERR: state_next = S_FINISH;
          endcase
        end
      end
      S_RD: begin
        corner_next = corner_t'(corner + 2'd1);
        if (corner == C11) state_next = S_RD_WAIT;
      end
      S_RD_WAIT: begin
        lstep_next = L_V0;
        state_next = S_LERP_A;
      end
      S_LERP_A: state_next = S_LERP_B;
      S_LERP_B: state_next = S_LERP_SUM;
      S_LERP_SUM: begin
        priority if (lstep == L_EY || (lstep == L_VY && !sts.use_err)) begin
          if (sts.keep_tot) begin
            sel_next   = DIV_VAL;
            state_next = S_DIV_START;
          end else begin
            state_next = S_FINISH;
          end
        end else begin
          lstep_next = lerp_step_t'(lstep + 3'd1);
          state_next = S_LERP_A;
        end
      end
      S_FINISH: begin
        if (sts.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.div_sel  = sel;
    cmd.corner   = corner;
    cmd.lerp_idx = lstep;
    in_ready     = (state == S_IDLE);
    unique case (state)
      S_IDLE:      cmd.load      = sts.item_valid;
      S_DIV_START: cmd.div_start = 1'b1;
      S_DIV_WAIT:  cmd.div_cap   = sts.div_done;
      S_RD:        cmd.rd_en     = 1'b1;
      S_LERP_A:    cmd.lerp_a    = 1'b1;
      S_LERP_B:    cmd.lerp_b    = 1'b1;
      S_LERP_SUM:  cmd.lerp_sum  = 1'b1;
      S_FINISH:    cmd.out_load  = sts.out_free;
      default: ;
    endcase
  end
endmodule

FILE: rtl/core/bvr_datapath.sv
// ----------------------------------------------------------------------------
// bvr_datapath: sample store and arithmetic of the resampler
// Configuration, frame memories, divider, interpolation multiplier and the
// result register.
// ----------------------------------------------------------------------------
module bvr_datapath
  import bvr_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data,
  input  logic                         item_valid,
  input  logic                         item_op,
  input  logic [PX_W-1:0]              item_x,
  input  logic [PX_W-1:0]              item_y,
  input  logic [SL_W-1:0]              item_slice,
  input  logic [VAL_W-1:0]             item_value,
  input  logic [ERR_W-1:0]             item_error,
  input  bvr_pkg::cmd_t                cmd,
  output bvr_pkg::sts_t                sts,
  input  logic                         out_ready,
  output logic                         out_valid,
  output logic [VAL_W-1:0]             out_value,
  output logic [ERR_W-1:0]             out_error,
  output logic                         out_bad
);
  logic [SIZE_W-1:0] old_w, old_h, new_w, new_h;
  logic [CNT_W-1:0]  slice_cnt;
  logic              use_err, keep_tot;

  always_ff @(posedge clk) begin
    if (rst) begin
      old_w     <= SIZE_W'(128);
      old_h     <= SIZE_W'(128);
      new_w     <= SIZE_W'(128);
      new_h     <= SIZE_W'(128);
      slice_cnt <= CNT_W'(16);
      use_err   <= 1'b0;
      keep_tot  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_OLD_WIDTH:   old_w     <= cfg_data;
        CFG_OLD_HEIGHT:  old_h     <= cfg_data;
        CFG_NEW_WIDTH:   new_w     <= cfg_data;
        CFG_NEW_HEIGHT:  new_h     <= cfg_data;
        CFG_SLICE_COUNT: slice_cnt <= cfg_data[CNT_W-1:0];
        CFG_USE_ERRORS:  use_err   <= cfg_data[0];
        CFG_KEEP_TOTAL:  keep_tot  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic [SIZE_W-1:0] ow, oh, nw, nh;
  logic [CNT_W-1:0]  sc;
  logic [AREA_W-1:0] area_num, area_den;

  assign ow = clamp_size(old_w, MAX_WIDTH);
  assign oh = clamp_size(old_h, MAX_HEIGHT);
  assign nw = clamp_size(new_w, MAX_WIDTH);
  assign nh = clamp_size(new_h, MAX_HEIGHT);
  assign sc = CNT_W'(clamp_size(SIZE_W'(slice_cnt), MAX_SLICES));

  always_ff @(posedge clk) begin
    area_num <= AREA_W'(ow) * AREA_W'(oh);
    area_den <= AREA_W'(nw) * AREA_W'(nh);
  end

  // range checks on the live item
  logic wr_ok, bad_live, we;
  assign wr_ok = (SIZE_W'(item_x) < ow) && (SIZE_W'(item_y) < oh)
              && (CNT_W'(item_slice) < sc);
  assign bad_live = !((SIZE_W'(item_x) < nw) && (SIZE_W'(item_y) < nh)
                   && (CNT_W'(item_slice) < sc));
  assign we = cmd.load && !item_op && wr_ok;

  logic [X_W-1:0] lx, x0, x1;
  logic [Y_W-1:0] ly, y0, y1;
  logic [S_W-1:0] lsl;
  logic           lbad;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      lx   <= item_x[X_W-1:0];
      ly   <= item_y[Y_W-1:0];
      lsl  <= item_slice[S_W-1:0];
      lbad <= bad_live;
    end
  end

  // frame memories
  logic [VAL_W-1:0] val_mem [0:DEPTH-1];
  logic [ERR_W-1:0] err_mem [0:DEPTH-1];
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [VAL_W-1:0] rd_val;
  logic [ERR_W-1:0] rd_err;

  assign wr_addr = {item_slice[S_W-1:0], item_y[Y_W-1:0], item_x[X_W-1:0]};

  always_comb begin
    unique case (cmd.corner)
      C00: rd_addr = {lsl, y0, x0};
      C10: rd_addr = {lsl, y0, x1};
      C01: rd_addr = {lsl, y1, x0};
      C11: rd_addr = {lsl, y1, x1};
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      val_mem[wr_addr] <= item_value;
      err_mem[wr_addr] <= item_error;
    end
    if (cmd.rd_en) begin
      rd_val <= val_mem[rd_addr];
      rd_err <= err_mem[rd_addr];
    end
  end

  logic    rd_q;
  corner_t rd_corner_q;
  logic [VAL_W-1:0] v00, v10, v01, v11;
  logic [ERR_W-1:0] e00, e10, e01, e11;

  always_ff @(posedge clk) begin
    if (rst) rd_q <= 1'b0;
    else     rd_q <= cmd.rd_en;
  end

  always_ff @(posedge clk) begin
    rd_corner_q <= cmd.corner;
    if (rd_q) begin
      unique case (rd_corner_q)
        C00: begin v00 <= rd_val; e00 <= rd_err; end
        C10: begin v10 <= rd_val; e10 <= rd_err; end
        C01: begin v01 <= rd_val; e01 <= rd_err; end
        C11: begin v11 <= rd_val; e11 <= rd_err; end
      endcase
    end
  end

  // divider operands
  logic [PX_W:0]       ax_odd;
  logic [SIZE_W-1:0]   ax_old, ax_new;
  logic [AREA_W-1:0]   ax_t, ax_n, ax_lim, ax_a, ax_i0, ax_i1;
  logic                ax_neg;
  logic [FRAC_BITS-1:0] ax_f;
  logic [VAL_W-1:0]    uval, mag;
  logic [VAL_W-1:0]    res_val;
  logic [ERR_W-1:0]    res_err;
  logic [VAL_W-1:0]    scale_src;
  logic [DIV_W-1:0]    div_dividend, quotient;
  logic [DVS_W-1:0]    div_divisor;
  logic                div_busy, div_done;

  always_comb begin
    if (cmd.div_sel == DIV_X) begin
      ax_odd = {PX_W'(lx), 1'b1};
      ax_old = ow;
      ax_new = nw;
    end else begin
      ax_odd = {PX_W'(ly), 1'b1};
      ax_old = oh;
      ax_new = nh;
    end
  end

  assign ax_t   = AREA_W'(ax_odd) * AREA_W'(ax_old);
  assign ax_neg = ax_t < AREA_W'(ax_new);
  assign ax_n   = ax_t - AREA_W'(ax_new);
  assign ax_lim = AREA_W'(ax_old) - AREA_W'(1);
  assign ax_a   = ax_neg ? '0 : quotient[FRAC_BITS +: AREA_W];
  assign ax_f   = ax_neg ? '0 : quotient[FRAC_BITS-1:0];
  assign ax_i0  = (ax_a > ax_lim) ? ax_lim : ax_a;
  assign ax_i1  = (ax_i0 + AREA_W'(1) > ax_lim) ? ax_lim : ax_i0 + AREA_W'(1);

  assign mag = uval[VAL_W-1] ? {1'b0, uval[VAL_W-2:0]} : SIGN_BIAS - uval;
  assign scale_src = (cmd.div_sel == DIV_VAL) ? mag : VAL_W'(res_err);

  always_comb begin
    if (cmd.div_sel == DIV_X || cmd.div_sel == DIV_Y) begin
      div_dividend = DIV_W'({ax_n, {FRAC_BITS{1'b0}}});
      div_divisor  = DVS_W'({ax_new, 1'b0});
    end else begin
      div_dividend = DIV_W'(scale_src) * DIV_W'(area_num) + DIV_W'(area_den >> 1);
      div_divisor  = area_den;
    end
  end

  bvr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (quotient)
  );

  // interpolation: one multiplier, products summed with round half up
  logic [FRAC_BITS-1:0] fx, fy, lf;
  logic [VAL_W-1:0]     opa, opb, l0, l1, mul_a;
  logic [WGT_W-1:0]     mul_w;
  logic [PROD_W-1:0]    prod, acc;
  logic [PROD_W:0]      lsum;
  logic [VAL_W-1:0]     lres;

  always_comb begin
    unique case (cmd.lerp_idx)
      L_V0: begin opa = v00 ^ SIGN_BIAS; opb = v10 ^ SIGN_BIAS; lf = fx; end
      L_V1: begin opa = v01 ^ SIGN_BIAS; opb = v11 ^ SIGN_BIAS; lf = fx; end
      L_E0: begin opa = VAL_W'(e00); opb = VAL_W'(e10); lf = fx; end
      L_E1: begin opa = VAL_W'(e01); opb = VAL_W'(e11); lf = fx; end
      L_VY, L_EY: begin opa = l0; opb = l1; lf = fy; end
      default: begin opa = l0; opb = l1; lf = fy; end
    endcase
  end

  assign mul_a = cmd.lerp_a ? opa : opb;
  assign mul_w = cmd.lerp_a ? (WGT_W'(1) << FRAC_BITS) - WGT_W'(lf) : WGT_W'(lf);
  assign lsum  = (PROD_W+1)'(acc) + (PROD_W+1)'(prod)
               + ((PROD_W+1)'(1) << (FRAC_BITS - 1));
  assign lres  = lsum[FRAC_BITS +: VAL_W];

  always_ff @(posedge clk) begin
    if (cmd.lerp_a || cmd.lerp_b) prod <= PROD_W'(mul_a) * PROD_W'(mul_w);
    if (cmd.lerp_b) acc <= prod;
    if (cmd.load) res_err <= '0;
    if (cmd.lerp_sum) begin
      unique case (cmd.lerp_idx)
        L_V0, L_E0: l0 <= lres;
        L_V1, L_E1: l1 <= lres;
        L_VY: begin
          uval    <= lres;
          res_val <= lres ^ SIGN_BIAS;
        end
        L_EY: res_err <= lres[ERR_W-1:0];
        default: ;
      endcase
    end
    if (cmd.div_cap) begin
      unique case (cmd.div_sel)
        DIV_X: begin
          x0 <= ax_i0[X_W-1:0];
          x1 <= ax_i1[X_W-1:0];
          fx <= ax_f;
        end
        DIV_Y: begin
          y0 <= ax_i0[Y_W-1:0];
          y1 <= ax_i1[Y_W-1:0];
          fy <= ax_f;
        end
        DIV_VAL: begin
          if (!uval[VAL_W-1]) begin
            res_val <= (quotient > DIV_W'(SIGN_BIAS)) ? SIGN_BIAS
                     : VAL_W'(0) - quotient[VAL_W-1:0];
          end else begin
            res_val <= (quotient > DIV_W'(VAL_MAX)) ? VAL_MAX : quotient[VAL_W-1:0];
          end
        end
        DIV_ERR: res_err <= (quotient > DIV_W'(ERR_MAX)) ? ERR_MAX
                          : quotient[ERR_W-1:0];
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_value <= lbad ? '0 : res_val;
      out_error <= lbad ? '0 : res_err;
      out_bad   <= lbad;
    end
  end

  always_comb begin
    sts.item_valid = item_valid;
    sts.op         = item_op;
    sts.bad        = bad_live;
    sts.div_busy   = div_busy;
    sts.div_done   = div_done;
    sts.use_err    = use_err;
    sts.keep_tot   = keep_tot;
    sts.out_free   = !out_valid || out_ready;
  end
endmodule
